### hw/rtl/elfh_pkg.sv
`timescale 1ns / 1ps

package elfh_pkg;

    localparam int HASH_W     = 32;
    localparam int CHAR_W     = 8;
    localparam int STEP_SHIFT = 4;
    localparam int FOLD_SHIFT = 24;
    localparam logic [HASH_W-1:0] TOP_MASK = 32'hf000_0000;

    // finished-string queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;

    // divider iteration count
    localparam int DIV_CNT_W = $clog2(HASH_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(HASH_W - 1);

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] divisor;
    } elfh_job_t;

    // one PJW step: shift in a signed char, fold the top nibble down
    function automatic logic [HASH_W-1:0] hash_update(
        input logic [HASH_W-1:0] h,
        input logic [CHAR_W-1:0] b
    );
        logic [HASH_W-1:0] sum;
        logic [HASH_W-1:0] top;
        sum = (h << STEP_SHIFT) + {{(HASH_W-CHAR_W){b[CHAR_W-1]}}, b};
        top = sum & TOP_MASK;
        return sum ^ (top >> FOLD_SHIFT) ^ top;
    endfunction

endpackage

### hw/rtl/elfh_front.sv
`timescale 1ns / 1ps

module elfh_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [elfh_pkg::CHAR_W-1:0] s_char_byte,
    input  logic                       s_last_char,
    input  logic                       cfg_wr_en,
    input  logic [elfh_pkg::HASH_W-1:0] cfg_wr_data,
    output logic                       job_push,
    output elfh_pkg::elfh_job_t        job_data,
    input  logic                       job_full
);
    import elfh_pkg::*;

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] divisor_reg;
    logic              accept;

    assign s_ready   = !job_full;
    assign accept    = s_valid && s_ready;
    assign hash_next = hash_update(hash_reg, s_char_byte);

    // a last char hands the finished hash to the back end
    assign job_push         = accept && s_last_char;
    assign job_data.hash    = hash_next;
    assign job_data.divisor = divisor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg    <= '0;
            divisor_reg <= '0;
        end else begin
            if (accept) begin
                hash_reg <= s_last_char ? '0 : hash_next;
            end
            if (cfg_wr_en) begin
                divisor_reg <= cfg_wr_data;
            end
        end
    end

endmodule

### hw/rtl/elfh_fifo.sv
`timescale 1ns / 1ps

module elfh_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  elfh_pkg::elfh_job_t push_data,
    output logic                full,
    input  logic                pop,
    output elfh_pkg::elfh_job_t pop_data,
    output logic                not_empty
);
    import elfh_pkg::*;

    elfh_job_t            entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !not_empty))
        else $error("queue underflow");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

### hw/rtl/elfh_mod.sv
`timescale 1ns / 1ps

module elfh_mod (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       job_valid,
    input  elfh_pkg::elfh_job_t        job_data,
    output logic                       job_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [elfh_pkg::HASH_W-1:0] m_bucket
);
    import elfh_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [HASH_W-1:0]    dvd_reg;
    logic [HASH_W-1:0]    div_reg;
    logic [HASH_W-1:0]    rem_reg;
    logic                 zero_div_reg;
    logic                 m_valid_reg;
    logic [HASH_W-1:0]    m_bucket_reg;

    logic [HASH_W:0]      rem_shift;
    logic [HASH_W:0]      rem_diff;
    logic [HASH_W-1:0]    rem_next;
    logic                 out_free;

    // restoring division, one quotient bit per cycle; only the remainder is kept
    assign rem_shift = {rem_reg, dvd_reg[HASH_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign rem_next  = rem_diff[HASH_W] ? rem_shift[HASH_W-1:0] : rem_diff[HASH_W-1:0];

    assign out_free = !m_valid_reg || m_ready;
    assign job_pop  = (state_reg == ST_IDLE) && job_valid;
    assign m_valid  = m_valid_reg;
    assign m_bucket = m_bucket_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                dvd_reg      <= job_data.hash;
                div_reg      <= job_data.divisor;
                zero_div_reg <= (job_data.divisor == '0);
                rem_reg      <= '0;
            end
            ST_RUN: begin
                rem_reg <= rem_next;
                dvd_reg <= dvd_reg << 1;
            end
            default: begin
            end
        endcase
        if (state_reg == ST_DONE && out_free) begin
            m_bucket_reg <= zero_div_reg ? '0 : rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_RUN) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                cnt_reg <= '0;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |=> (state_reg == ST_RUN) && (cnt_reg == '0))
        else $error("job taken without starting a division");

    a_run_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && (cnt_reg == DIV_LAST) |=> (state_reg == ST_DONE))
        else $error("division did not finish after full count");

    a_zero_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && out_free && zero_div_reg |=> m_valid && (m_bucket == '0))
        else $error("zero divisor gave nonzero bucket");
`endif

endmodule

### hw/rtl/elf_string_hash_modulo_unit.sv
`timescale 1ns / 1ps

// ELF (PJW) string hash with reduction modulo a table size.
// Input channel (s_valid/s_ready): one character word per transfer,
//   s_char_byte added as a signed char, s_last_char ends the string.
// Output channel (m_valid/m_ready): one m_bucket word per string,
//   hash % divisor, or 0 when the divisor is 0.
// Config: cfg_wr_en/cfg_wr_data write the divisor; change it
//   only while no string is in flight.
// Throughput: characters go in at one per cycle while s_ready is high;
//   the hash update is a single shift/add/fold per clock in the front end.
// Path: the edge that takes the last character also writes the finished
//   hash into the queue; the divider then loads it, runs the bit-serial
//   restoring division one quotient bit per step, and writes the
//   remainder into the output register, which drives m_valid.
//   Strings are reduced one at a time.
// A two-entry queue between the hash front end and the divider lets the
//   next string stream in while the current one is reduced; s_ready drops
//   only when that queue is full. A stalled m_ready holds the result and
//   the divider, then backs up into the queue.
// Reset (aresetn low, synchronous) clears the hash, the divisor, the queue
//   and the output valid.
module elf_string_hash_modulo_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [elfh_pkg::CHAR_W-1:0] s_char_byte,
    input  logic                        s_last_char,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [elfh_pkg::HASH_W-1:0] m_bucket,
    input  logic                        cfg_wr_en,
    input  logic [elfh_pkg::HASH_W-1:0] cfg_wr_data
);
    import elfh_pkg::*;

    // front end -> queue
    logic      job_push;
    elfh_job_t job_in;
    logic      job_full;

    // queue -> divider
    logic      job_pop;
    elfh_job_t job_out;
    logic      job_avail;

    elfh_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_byte (s_char_byte),
        .s_last_char (s_last_char),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .job_push    (job_push),
        .job_data    (job_in),
        .job_full    (job_full)
    );

    elfh_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .not_empty (job_avail)
    );

    elfh_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_avail),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_bucket  (m_bucket)
    );

endmodule
